/* rtl/core/mac_flow_accounting_table_top_defines.svh */
// Assertion macros used by the port-level checker of the flow accounting table.
`ifndef MAC_FLOW_ACCOUNTING_TABLE_TOP_DEFINES_SVH
`define MAC_FLOW_ACCOUNTING_TABLE_TOP_DEFINES_SVH

// Checked on every clock edge outside of reset.
`define MFAT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define MFAT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/mfat_pkg.sv */
// Types and constants of the MAC flow accounting table.
package mfat_pkg;

  localparam int MAC_W   = 48;
  localparam int IP_W    = 32;
  localparam int FLOW_W  = 16;
  localparam int IV_W    = 32;
  localparam int TOT_W   = 64;
  localparam int IDLE_W  = 8;
  localparam int MODE_W  = 2;
  localparam int STAT_W  = 3;
  localparam int REM_W   = 7;

  localparam logic [IDLE_W-1:0] IDLE_LIMIT_RESET = 8'd20;
  localparam logic [IDLE_W-1:0] IDLE_MAX         = 8'hFF;

  localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REPORT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_PURGE  = 2'd3;

  localparam logic [STAT_W-1:0] ST_UPDATED  = 3'd0;
  localparam logic [STAT_W-1:0] ST_INSERTED = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STAT_W-1:0] ST_RECORD   = 3'd3;
  localparam logic [STAT_W-1:0] ST_DONE     = 3'd4;

  typedef struct packed {
    logic [MAC_W-1:0]  mac;
    logic [IP_W-1:0]   ip;
    logic [IV_W-1:0]   interval;
    logic [TOT_W-1:0]  total;
    logic [IDLE_W-1:0] idle;
  } slot_data_t;

  typedef struct packed {
    logic       valid;
    slot_data_t data;
  } slot_t;

endpackage

/* rtl/core/mfat_if.sv */
// Valid/ready channels for input words and result words.
interface mfat_in_if;
  logic                            valid;
  logic                            ready;
  logic [mfat_pkg::MODE_W-1:0]     mode;
  logic [mfat_pkg::MAC_W-1:0]      station_mac;
  logic [mfat_pkg::IP_W-1:0]       station_ip;
  logic [mfat_pkg::FLOW_W-1:0]     flow_amount;

  modport source (output valid, mode, station_mac, station_ip, flow_amount, input ready);
  modport sink (input valid, mode, station_mac, station_ip, flow_amount, output ready);
endinterface

interface mfat_out_if;
  logic                            valid;
  logic                            ready;
  logic [mfat_pkg::STAT_W-1:0]     status;
  logic [mfat_pkg::MAC_W-1:0]      rec_mac;
  logic [mfat_pkg::IP_W-1:0]       rec_ip;
  logic [mfat_pkg::IV_W-1:0]       rec_interval;
  logic [mfat_pkg::TOT_W-1:0]      rec_total;
  logic [mfat_pkg::REM_W-1:0]      removed_count;
  logic                            last;

  modport source (output valid, status, rec_mac, rec_ip, rec_interval, rec_total,
                  removed_count, last, input ready);
  modport sink (input valid, status, rec_mac, rec_ip, rec_interval, rec_total,
                removed_count, last, output ready);
endinterface

/* rtl/core/mfat_cell.sv */
// One table slot of the rotating ring; takes its neighbor's slot on each shift.
module mfat_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             shift,
  input  mfat_pkg::slot_t  d,
  output mfat_pkg::slot_t  q
);

  logic                 valid;
  mfat_pkg::slot_data_t data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= d.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      data <= d.data;
    end
  end

  assign q = '{valid: valid, data: data};

endmodule

/* rtl/core/mac_flow_accounting_table_top.sv */
// Top level of the MAC flow accounting table: slot ring and its controller.
// Usage:
// An input word arrives on the item channel (valid/ready) and carries a mode:
// add flow, report tick, clear intervals or purge idle stations. Result words
// leave on the result channel; the final word of an input word has last set.
// The idle limit register is written through cfg_we/cfg_wdata; the user
// writes it only while idle, and the block itself does not enforce this.
// The slots sit in a ring of ENTRIES cells that rotates by one slot a cycle
// while it shifts, and holds still while idle and when a report stalls;
// a single update unit works on the slot at the head of the ring.
// One input word is taken at a time; the next one is taken in the cycle after
// the final result word is loaded. Clear and purge sweep all ENTRIES slots.
// Add scans all ENTRIES slots; an update or a full table answers after the
// scan, and an insert then waits for the free slot to come round.
// Report first turns the ring back to slot 0, then scans ENTRIES slots.
// Reset empties the table, sets the idle limit to 20 and drops any result.
// When the receiver stalls, the result register holds its word; in report
// mode the ring stops until the next record can be handed over.
module mac_flow_accounting_table_top #(
  parameter int ENTRIES = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [mfat_pkg::IDLE_W-1:0]   cfg_wdata,
  mfat_in_if.sink                       item,
  mfat_out_if.source                    result
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);
  localparam logic [CW-1:0] LAST_CNT = CW'(ENTRIES - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_ADD_SCAN, S_ADD_SEEK, S_ALIGN, S_REPORT, S_FLUSH, S_SWEEP, S_DONE
  } state_t;

  state_t                          state;
  logic [mfat_pkg::IDLE_W-1:0]     idle_limit;
  logic [mfat_pkg::MODE_W-1:0]     mode;
  logic [mfat_pkg::MAC_W-1:0]      mac;
  logic [mfat_pkg::IP_W-1:0]       ip;
  logic [mfat_pkg::FLOW_W-1:0]     flow;
  logic [IW-1:0]                   ptr;
  logic [CW-1:0]                   cnt;
  logic                            matched;
  logic                            free_found;
  logic [IW-1:0]                   free_idx;
  logic [mfat_pkg::REM_W-1:0]      removed;
  logic [mfat_pkg::STAT_W-1:0]     res_status;
  logic                            pvalid;
  mfat_pkg::slot_data_t            prec;
  logic [mfat_pkg::IV_W-1:0]       piv;

  logic                            ovalid;
  logic [mfat_pkg::STAT_W-1:0]     o_status;
  logic [mfat_pkg::MAC_W-1:0]      o_mac;
  logic [mfat_pkg::IP_W-1:0]       o_ip;
  logic [mfat_pkg::IV_W-1:0]       o_iv;
  logic [mfat_pkg::TOT_W-1:0]      o_total;
  logic [mfat_pkg::REM_W-1:0]      o_removed;
  logic                            o_last;

  mfat_pkg::slot_t ring [ENTRIES];
  mfat_pkg::slot_t head;
  mfat_pkg::slot_t tail_in;
  logic            shift;
  logic            can_emit;
  logic            load_out;
  logic            hit;
  logic [mfat_pkg::IV_W:0] sat_sum;
  logic [mfat_pkg::IV_W-1:0] sat_iv;

  assign head     = ring[0];
  assign can_emit = !ovalid || result.ready;
  assign hit      = head.valid && (head.data.mac == mac);
  assign sat_sum  = {1'b0, head.data.interval} + {{(mfat_pkg::IV_W - mfat_pkg::FLOW_W + 1){1'b0}}, flow};
  assign sat_iv   = sat_sum[mfat_pkg::IV_W] ? {mfat_pkg::IV_W{1'b1}} : sat_sum[mfat_pkg::IV_W-1:0];
  assign load_out = ((state == S_REPORT) && shift && head.valid && pvalid)
                 || (((state == S_FLUSH) || (state == S_DONE)) && can_emit);

  genvar g;
  generate
    for (g = 0; g < ENTRIES; g++) begin : g_cell
      mfat_pkg::slot_t d;
      if (g == ENTRIES - 1) begin : g_tail
        assign d = tail_in;
      end else begin : g_mid
        assign d = ring[g+1];
      end
      mfat_cell u_cell (.clk(clk), .rst(rst), .shift(shift), .d(d), .q(ring[g]));
    end
  endgenerate

  // Update unit for the slot at the head of the ring.
  always_comb begin
    shift   = 1'b0;
    tail_in = head;
    case (state)
      S_ADD_SCAN: begin
        shift = 1'b1;
        if (hit) begin
          tail_in.data.interval = sat_iv;
          tail_in.data.ip       = ip;
        end
      end
      S_ADD_SEEK: begin
        shift = 1'b1;
        if (ptr == free_idx) begin
          tail_in.valid         = 1'b1;
          tail_in.data.mac      = mac;
          tail_in.data.ip       = ip;
          tail_in.data.interval = {{(mfat_pkg::IV_W - mfat_pkg::FLOW_W){1'b0}}, flow};
          tail_in.data.total    = '0;
          tail_in.data.idle     = '0;
        end
      end
      S_ALIGN: begin
        shift = (ptr != '0);
      end
      S_REPORT: begin
        shift = !(head.valid && pvalid && !can_emit);
        if (head.valid) begin
          tail_in.data.total    = head.data.total
                                + {{(mfat_pkg::TOT_W - mfat_pkg::IV_W){1'b0}}, head.data.interval};
          tail_in.data.interval = '0;
          if (head.data.interval == '0) begin
            if (head.data.idle != mfat_pkg::IDLE_MAX) begin
              tail_in.data.idle = head.data.idle + 1'b1;
            end
          end else begin
            tail_in.data.idle = '0;
          end
        end
      end
      S_SWEEP: begin
        shift = 1'b1;
        if (mode == mfat_pkg::MODE_CLEAR) begin
          tail_in.data.interval = '0;
        end else if (head.valid && head.data.idle >= idle_limit) begin
          tail_in.valid = 1'b0;
        end
      end
      default: begin
        shift = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_limit <= mfat_pkg::IDLE_LIMIT_RESET;
    end else if (cfg_we) begin
      idle_limit <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      ptr    <= '0;
      ovalid <= 1'b0;
      pvalid <= 1'b0;
    end else begin
      if (load_out) begin
        ovalid <= 1'b1;
      end else if (result.ready) begin
        ovalid <= 1'b0;
      end
      if (shift) begin
        ptr <= (ptr == LAST_IDX) ? '0 : ptr + 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (item.valid) begin
            mode       <= item.mode;
            mac        <= item.station_mac;
            ip         <= item.station_ip;
            flow       <= item.flow_amount;
            cnt        <= '0;
            matched    <= 1'b0;
            free_found <= 1'b0;
            removed    <= '0;
            pvalid     <= 1'b0;
            case (item.mode)
              mfat_pkg::MODE_ADD:    state <= S_ADD_SCAN;
              mfat_pkg::MODE_REPORT: state <= S_ALIGN;
              default:               state <= S_SWEEP;
            endcase
          end
        end
        S_ADD_SCAN: begin
          cnt <= cnt + 1'b1;
          if (hit) begin
            matched <= 1'b1;
          end
          // The scan may start anywhere in the ring; keep the lowest free slot.
          if (!head.valid && (!free_found || (ptr < free_idx))) begin
            free_found <= 1'b1;
            free_idx   <= ptr;
          end
          if (cnt == LAST_CNT) begin
            if (matched || hit) begin
              res_status <= mfat_pkg::ST_UPDATED;
              state      <= S_DONE;
            end else if (free_found || !head.valid) begin
              state <= S_ADD_SEEK;
            end else begin
              res_status <= mfat_pkg::ST_FULL;
              state      <= S_DONE;
            end
          end
        end
        S_ADD_SEEK: begin
          if (ptr == free_idx) begin
            res_status <= mfat_pkg::ST_INSERTED;
            state      <= S_DONE;
          end
        end
        S_ALIGN: begin
          if (ptr == '0) begin
            state <= S_REPORT;
          end
        end
        S_REPORT: begin
          if (shift) begin
            cnt <= cnt + 1'b1;
            if (head.valid) begin
              // The held record goes out now: a later valid slot exists.
              if (pvalid) begin
                o_status  <= mfat_pkg::ST_RECORD;
                o_mac     <= prec.mac;
                o_ip      <= prec.ip;
                o_iv      <= piv;
                o_total   <= prec.total;
                o_removed <= '0;
                o_last    <= 1'b0;
              end
              pvalid <= 1'b1;
              prec   <= tail_in.data;
              piv    <= head.data.interval;
            end
            if (cnt == LAST_CNT) begin
              state <= S_FLUSH;
            end
          end
        end
        S_FLUSH: begin
          if (can_emit) begin
            o_status  <= pvalid ? mfat_pkg::ST_RECORD : mfat_pkg::ST_DONE;
            o_mac     <= pvalid ? prec.mac : '0;
            o_ip      <= pvalid ? prec.ip : '0;
            o_iv      <= pvalid ? piv : '0;
            o_total   <= pvalid ? prec.total : '0;
            o_removed <= '0;
            o_last    <= 1'b1;
            pvalid    <= 1'b0;
            state     <= S_IDLE;
          end
        end
        S_SWEEP: begin
          cnt <= cnt + 1'b1;
          if (mode == mfat_pkg::MODE_PURGE && head.valid && head.data.idle >= idle_limit) begin
            removed <= removed + 1'b1;
          end
          if (cnt == LAST_CNT) begin
            res_status <= mfat_pkg::ST_DONE;
            state      <= S_DONE;
          end
        end
        S_DONE: begin
          if (can_emit) begin
            o_status  <= res_status;
            o_mac     <= '0;
            o_ip      <= '0;
            o_iv      <= '0;
            o_total   <= '0;
            o_removed <= removed;
            o_last    <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign item.ready           = (state == S_IDLE);
  assign result.valid         = ovalid;
  assign result.status        = o_status;
  assign result.rec_mac       = o_mac;
  assign result.rec_ip        = o_ip;
  assign result.rec_interval  = o_iv;
  assign result.rec_total     = o_total;
  assign result.removed_count = o_removed;
  assign result.last          = o_last;

endmodule

/* rtl/core/mfat_checker.sv */
// Port-level checks of the flow accounting table and their binding.
`include "mac_flow_accounting_table_top_defines.svh"

module mfat_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [mfat_pkg::STAT_W-1:0]   out_status,
  input logic [mfat_pkg::MAC_W-1:0]    out_mac,
  input logic [mfat_pkg::TOT_W-1:0]    out_total,
  input logic [mfat_pkg::REM_W-1:0]    out_removed,
  input logic                          out_last
);

  // A word that is not taken stays offered.
  `MFAT_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result word dropped")
  // One input word is worked on at a time.
  `MFAT_ASSERT(a_one_item, in_valid && in_ready |=> !in_ready, "second word taken while busy")
  // Only record words carry entry data.
  `MFAT_ASSERT(a_zero_fields, out_valid && out_status != mfat_pkg::ST_RECORD |-> out_mac == '0 && out_total == '0, "entry data on a status word")
  // A purge count only appears on a final done word.
  `MFAT_ASSERT(a_removed, out_valid && out_removed != '0 |-> out_status == mfat_pkg::ST_DONE && out_last, "stray removed count")
  // Reset leaves no result offered.
  `MFAT_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "result offered after reset")

endmodule

bind mac_flow_accounting_table_top mfat_checker u_mfat_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (item.valid),
  .in_ready    (item.ready),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .out_status  (result.status),
  .out_mac     (result.rec_mac),
  .out_total   (result.rec_total),
  .out_removed (result.removed_count),
  .out_last    (result.last)
);
